>>> design/etmb_pkg.sv
// shared types, constants and arithmetic helpers for the trs matrix builder
package etmb_pkg;

   // cordic stage count limits and default
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_ENTRIES = 24;

   // one front cell per quotient bit of the reciprocal 2^24 / scale
   localparam int FRONT_LEN = 25;
   // register stages of the rotation and scaling section
   localparam int ROT_STAGES = 5;

   localparam logic signed [16:0] PI_Q13 = 17'sd25736;
   localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [31:0] INV_SAT = 32'sh7FFF_FFFF;

   // command codes
   localparam logic CMD_MODEL = 1'b0;
   localparam logic CMD_NORMAL = 1'b1;

   // per-axis state carried through the front cells
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               neg_cos;
      logic signed [15:0] scale;
      logic        [15:0] dmag;
      logic        [15:0] rem;
      logic        [24:0] quot;
   } lane_type;

   // word moving from one front cell to the next
   typedef struct packed {
      lane_type [2:0]    lane;
      logic              cmd;
      logic [2:0][31:0]  pos;
   } cell_type;

   // finished matrix handed to the output stage
   typedef struct packed {
      logic [2:0][2:0][31:0] elem;
      logic [2:0]            zero;
      logic                  cmd;
      logic [2:0][31:0]      pos;
   } mat_type;

   // arctangent of 2^-i in q2.30
   function automatic logic signed [33:0] atan_q30(input int i);
      logic [30:0] v;
      case (i)
         0: v = 31'd843314857;
         1: v = 31'd497837829;
         2: v = 31'd263043837;
         3: v = 31'd133525159;
         4: v = 31'd67021687;
         5: v = 31'd33543516;
         6: v = 31'd16775851;
         7: v = 31'd8388437;
         8: v = 31'd4194283;
         9: v = 31'd2097149;
         10: v = 31'd1048576;
         11: v = 31'd524288;
         12: v = 31'd262144;
         13: v = 31'd131072;
         14: v = 31'd65536;
         15: v = 31'd32768;
         16: v = 31'd16384;
         17: v = 31'd8192;
         18: v = 31'd4096;
         19: v = 31'd2048;
         20: v = 31'd1024;
         21: v = 31'd512;
         22: v = 31'd256;
         23: v = 31'd128;
         default: v = 31'd0;
      endcase
      return signed'({3'b000, v});
   endfunction

   // q2.30 product rounded half up
   function automatic logic signed [33:0] mul_q30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      p = p + 64'sd536870912;
      return signed'(p[63:30]);
   endfunction

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = signed'(v[31:0]);
      end
      return r;
   endfunction

endpackage

>>> design/euler_trs_matrix_builder.sv
// top level: yxz euler trs / normal matrix builder, one column word per cycle while rsp_stall is low
//
//  channel | direction | words
//  req_    | in        | command, three angles, three scales, position
//  rsp_    | out       | one column: index, three elements, last, zero flag
//
// a word passes 25 front cells (one reciprocal quotient bit each, plus a cordic
// micro-rotation below CORDIC_STAGES and ATAN_ENTRIES), 5 rotor stages and the output register.
// the output register sends 4 columns for a model matrix and 3 for a normal
// matrix, and loads the next one only when idle or as its last column is sent.
// reset is synchronous and clears only the valid bits, the busy flag and the column counter.
// the whole pipe freezes while a finished word waits in its last stage for the
// output register, and req_stall is high for exactly those cycles.
module euler_trs_matrix_builder #(
   parameter int CORDIC_STAGES = etmb_pkg::CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic signed [15:0] req_angle_x,
   input  logic signed [15:0] req_angle_y,
   input  logic signed [15:0] req_angle_z,
   input  logic signed [15:0] req_scale_x,
   input  logic signed [15:0] req_scale_y,
   input  logic signed [15:0] req_scale_z,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_column_index,
   output logic signed [31:0] rsp_elem_a,
   output logic signed [31:0] rsp_elem_b,
   output logic signed [31:0] rsp_elem_c,
   output logic               rsp_last_column,
   output logic               rsp_zero_scale
);
   import etmb_pkg::*;

   localparam int PIPE_LEN = FRONT_LEN + ROT_STAGES;

   logic adv;
   logic accept;
   logic [PIPE_LEN-1:0] v_ff;

   // input preparation: angle reduction and divider seed
   cell_type chain [FRONT_LEN+1];

   always_comb begin
      logic signed [15:0] ang [3];
      logic signed [15:0] scl [3];
      logic signed [16:0] a;
      logic signed [16:0] red;
      logic neg;
      ang[0] = req_angle_x;
      ang[1] = req_angle_y;
      ang[2] = req_angle_z;
      scl[0] = req_scale_x;
      scl[1] = req_scale_y;
      scl[2] = req_scale_z;
      chain[0].cmd = req_command;
      chain[0].pos[0] = req_pos_x;
      chain[0].pos[1] = req_pos_y;
      chain[0].pos[2] = req_pos_z;
      for (int i = 0; i < 3; i++) begin
         a = 17'(ang[i]);
         red = a;
         neg = 1'b0;
         if (a > HALF_PI_Q13) begin
            red = PI_Q13 - a;
            neg = 1'b1;
         end else if (a < -HALF_PI_Q13) begin
            red = -PI_Q13 - a;
            neg = 1'b1;
         end
         chain[0].lane[i].x = CORDIC_X0;
         chain[0].lane[i].y = 34'sd0;
         chain[0].lane[i].z = {red, 17'b0};
         chain[0].lane[i].neg_cos = neg;
         chain[0].lane[i].scale = scl[i];
         chain[0].lane[i].dmag = scl[i][15] ? 16'(-scl[i]) : 16'(scl[i]);
         chain[0].lane[i].rem = 16'd0;
         chain[0].lane[i].quot = 25'd0;
      end
   end

   // row of front cells
   for (genvar j = 0; j < FRONT_LEN; j++) begin : g_cell
      etmb_cell #(
         .STEP(j),
         .CORDIC_STAGES(CORDIC_STAGES)
      ) u_cell (
         .clock(clock),
         .en(adv),
         .cell_in(chain[j]),
         .cell_out(chain[j+1])
      );
   end

   // rotation and scaling stages
   mat_type mat_w;

   etmb_rotor u_rotor (
      .clock(clock),
      .en(adv),
      .cell_in(chain[FRONT_LEN]),
      .mat_out(mat_w)
   );

   // output register and column sequencing
   mat_type    out_ff;
   logic       busy_ff;
   logic [1:0] col_ff;
   logic [1:0] last_col;
   logic       fire;
   logic       done;
   logic       can_load;
   logic       load;

   assign last_col = (out_ff.cmd == CMD_NORMAL) ? 2'd2 : 2'd3;
   assign fire = busy_ff && !rsp_stall;
   assign done = fire && (col_ff == last_col);
   assign can_load = !busy_ff || done;
   assign load = v_ff[PIPE_LEN-1] && can_load;
   assign adv = !v_ff[PIPE_LEN-1] || can_load;
   assign accept = req_valid && adv;
   assign req_stall = !adv;

   // valid bits follow the words down the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[PIPE_LEN-2:0], accept};
      end
   end

   // column counter and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         col_ff <= 2'd0;
      end else if (load) begin
         busy_ff <= 1'b1;
         col_ff <= 2'd0;
      end else if (done) begin
         busy_ff <= 1'b0;
         col_ff <= 2'd0;
      end else if (fire) begin
         col_ff <= col_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= mat_w;
      end
   end

   // column select
   always_comb begin
      rsp_valid = busy_ff;
      rsp_column_index = col_ff;
      rsp_last_column = (col_ff == last_col);
      if (col_ff == 2'd3) begin
         rsp_elem_a = signed'(out_ff.pos[0]);
         rsp_elem_b = signed'(out_ff.pos[1]);
         rsp_elem_c = signed'(out_ff.pos[2]);
         rsp_zero_scale = 1'b0;
      end else begin
         rsp_elem_a = signed'(out_ff.elem[col_ff][0]);
         rsp_elem_b = signed'(out_ff.elem[col_ff][1]);
         rsp_elem_c = signed'(out_ff.elem[col_ff][2]);
         rsp_zero_scale = out_ff.zero[col_ff];
      end
   end

endmodule

>>> design/etmb_cell.sv
// front cell: a reciprocal quotient bit per axis and a cordic rotation if ITER
module etmb_cell #(
   parameter int STEP = 0,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                clock,
   input  logic                en,
   input  etmb_pkg::cell_type  cell_in,
   output etmb_pkg::cell_type  cell_out
);
   import etmb_pkg::*;

   localparam bit ITER = (STEP < CORDIC_STAGES) && (STEP < ATAN_ENTRIES);
   localparam logic NUM_BIT = (STEP == 0);

   cell_type cell_ff;
   cell_type cell_in_w;

   // rotate and divide each axis independently
   always_comb begin
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] atn;
      logic [16:0] t;
      logic qbit;
      cell_in_w = cell_in;
      atn = atan_q30(STEP);
      for (int i = 0; i < 3; i++) begin
         dx = cell_in.lane[i].y >>> STEP;
         dy = cell_in.lane[i].x >>> STEP;
         if (ITER) begin
            if (!cell_in.lane[i].z[33]) begin
               cell_in_w.lane[i].x = cell_in.lane[i].x - dx;
               cell_in_w.lane[i].y = cell_in.lane[i].y + dy;
               cell_in_w.lane[i].z = cell_in.lane[i].z - atn;
            end else begin
               cell_in_w.lane[i].x = cell_in.lane[i].x + dx;
               cell_in_w.lane[i].y = cell_in.lane[i].y - dy;
               cell_in_w.lane[i].z = cell_in.lane[i].z + atn;
            end
         end
         // restoring division step of 2^24 by the scale magnitude
         t = {cell_in.lane[i].rem, NUM_BIT};
         qbit = (t >= {1'b0, cell_in.lane[i].dmag});
         if (qbit) begin
            cell_in_w.lane[i].rem = 16'(t - {1'b0, cell_in.lane[i].dmag});
         end else begin
            cell_in_w.lane[i].rem = t[15:0];
         end
         cell_in_w.lane[i].quot = {cell_in.lane[i].quot[23:0], qbit};
      end
   end

   // hand the word on
   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in_w;
      end
   end

   assign cell_out = cell_ff;

endmodule

>>> design/etmb_rotor.sv
// rotation products, scaling and rounding to q16.16 columns
module etmb_rotor (
   input  logic                clock,
   input  logic                en,
   input  etmb_pkg::cell_type  cell_in,
   output etmb_pkg::mat_type   mat_out
);
   import etmb_pkg::*;

   // stage 1: sines, cosines, scale operands
   logic signed [31:0] s_ff [3];
   logic signed [31:0] c_ff [3];
   logic signed [31:0] op_ff [3];
   logic [2:0]         z1_ff;
   logic               cmd1_ff;
   logic [2:0][31:0]   pos1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            logic signed [31:0] q;
            logic signed [31:0] inv;
            logic zr;
            zr = (cell_in.lane[i].dmag == 16'd0);
            q = signed'({7'b0, cell_in.lane[i].quot});
            inv = cell_in.lane[i].scale[15] ? -q : q;
            if (zr) begin
               inv = INV_SAT;
            end
            s_ff[i] <= signed'(cell_in.lane[i].y[31:0]);
            c_ff[i] <= cell_in.lane[i].neg_cos ? signed'(32'(-cell_in.lane[i].x))
                                               : signed'(cell_in.lane[i].x[31:0]);
            op_ff[i] <= (cell_in.cmd == CMD_NORMAL) ? inv : 32'(cell_in.lane[i].scale);
            z1_ff[i] <= zr;
         end
         cmd1_ff <= cell_in.cmd;
         pos1_ff <= cell_in.pos;
      end
   end

   // axis x gives s2 c2, axis y gives s1 c1, axis z gives s3 c3
   logic signed [31:0] s1, c1, s2, c2, s3, c3;
   assign s1 = s_ff[1];
   assign c1 = c_ff[1];
   assign s2 = s_ff[0];
   assign c2 = c_ff[0];
   assign s3 = s_ff[2];
   assign c3 = c_ff[2];

   // stage 2: first-level products
   logic signed [31:0] c1c3_ff, s1s2_ff, c2s3_ff, c1s2_ff, c3s1_ff;
   logic signed [31:0] c1s3_ff, c2c3_ff, s1s3_ff, c2s1_ff, c1c2_ff;
   logic signed [31:0] s2_ff, s3_ff;
   logic signed [31:0] op2_ff [3];
   logic [2:0]         z2_ff;
   logic               cmd2_ff;
   logic [2:0][31:0]   pos2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c1c3_ff <= 32'(mul_q30(c1, c3));
         s1s2_ff <= 32'(mul_q30(s1, s2));
         c2s3_ff <= 32'(mul_q30(c2, s3));
         c1s2_ff <= 32'(mul_q30(c1, s2));
         c3s1_ff <= 32'(mul_q30(c3, s1));
         c1s3_ff <= 32'(mul_q30(c1, s3));
         c2c3_ff <= 32'(mul_q30(c2, c3));
         s1s3_ff <= 32'(mul_q30(s1, s3));
         c2s1_ff <= 32'(mul_q30(c2, s1));
         c1c2_ff <= 32'(mul_q30(c1, c2));
         s2_ff <= s2;
         s3_ff <= s3;
         op2_ff <= op_ff;
         z2_ff <= z1_ff;
         cmd2_ff <= cmd1_ff;
         pos2_ff <= pos1_ff;
      end
   end

   // stage 3: rotation entries, rot_ff[k][r] is row r of column k
   logic signed [33:0] rot_ff [3][3];
   logic signed [31:0] op3_ff [3];
   logic [2:0]         z3_ff;
   logic               cmd3_ff;
   logic [2:0][31:0]   pos3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff[0][0] <= 34'(c1c3_ff) + mul_q30(s1s2_ff, s3_ff);
         rot_ff[0][1] <= 34'(c2s3_ff);
         rot_ff[0][2] <= mul_q30(c1s2_ff, s3_ff) - 34'(c3s1_ff);
         rot_ff[1][0] <= mul_q30(c3s1_ff, s2_ff) - 34'(c1s3_ff);
         rot_ff[1][1] <= 34'(c2c3_ff);
         rot_ff[1][2] <= mul_q30(c1c3_ff, s2_ff) + 34'(s1s3_ff);
         rot_ff[2][0] <= 34'(c2s1_ff);
         rot_ff[2][1] <= -34'(s2_ff);
         rot_ff[2][2] <= 34'(c1c2_ff);
         op3_ff <= op2_ff;
         z3_ff <= z2_ff;
         cmd3_ff <= cmd2_ff;
         pos3_ff <= pos2_ff;
      end
   end

   // stage 4: scale or reciprocal product
   logic signed [65:0] prod_ff [3][3];
   logic [2:0]         z4_ff;
   logic               cmd4_ff;
   logic [2:0][31:0]   pos4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            for (int r = 0; r < 3; r++) begin
               prod_ff[k][r] <= rot_ff[k][r] * op3_ff[k];
            end
         end
         z4_ff <= z3_ff;
         cmd4_ff <= cmd3_ff;
         pos4_ff <= pos3_ff;
      end
   end

   // stage 5: round half up, shift to q16.16, saturate
   mat_type mat_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            for (int r = 0; r < 3; r++) begin
               logic signed [65:0] rnd;
               if (cmd4_ff == CMD_NORMAL) begin
                  rnd = (prod_ff[k][r] + 66'sd536870912) >>> 30;
               end else begin
                  rnd = (prod_ff[k][r] + 66'sd2097152) >>> 22;
               end
               mat_ff.elem[k][r] <= sat32(rnd);
            end
         end
         mat_ff.zero <= (cmd4_ff == CMD_NORMAL) ? z4_ff : 3'b000;
         mat_ff.cmd <= cmd4_ff;
         mat_ff.pos <= pos4_ff;
      end
   end

   assign mat_out = mat_ff;

endmodule
